// ===== sv/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg
// shared types and constants of the vertex transform pipeline
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int VTP_FRAC_BITS  = 16;
    localparam int VTP_COEF_DEPTH = 64;
    localparam int VTP_ADDR_W     = $clog2(VTP_COEF_DEPTH);

    localparam logic signed [31:0] VTP_MAX32 = 32'sh7fff_ffff;
    localparam logic signed [31:0] VTP_MIN32 = 32'sh8000_0000;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [1:0] MAT_WORLD = 2'd0;
    localparam logic [1:0] MAT_VIEW  = 2'd1;
    localparam logic [1:0] MAT_PROJ  = 2'd2;
    localparam logic [1:0] MAT_PORT  = 2'd3;

    localparam logic [1:0] STAGE_WORLD  = 2'd0;
    localparam logic [1:0] STAGE_VIEW   = 2'd1;
    localparam logic [1:0] STAGE_SCREEN = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [1:0]         matrix_select;
        logic [3:0]         element_index;
        logic signed [31:0] coefficient;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_vtp_in;

    typedef struct packed {
        logic [1:0]         stage;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               w_zero;
        logic               last;
    } t_vtp_out;

    typedef struct packed {
        logic mul;
        logic acc;
        logic first;
    } t_vtp_mac_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_COL,
        S_EMIT,
        S_DIVSEL,
        S_DIVGO,
        S_DIVWAIT
    } t_vtp_state;

endpackage

// ===== sv/vtp_coef_mem.sv =====
// ----------------------------------------------------------------------------
// vtp_coef_mem
// coefficient store, one write and one registered read port, per-entry valid
// ----------------------------------------------------------------------------
module vtp_coef_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [vtp_pkg::VTP_ADDR_W-1:0]   i_waddr,
    input  logic signed [31:0]               i_wdata,
    input  logic [vtp_pkg::VTP_ADDR_W-1:0]   i_raddr,
    output logic signed [31:0]               o_rdata
);
    import vtp_pkg::*;

    logic signed [31:0]        r_mem [VTP_COEF_DEPTH];
    logic [VTP_COEF_DEPTH-1:0] r_vld;
    logic signed [31:0]        r_rd;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : 32'sd0;

endmodule

// ===== sv/vtp_mac.sv =====
// ----------------------------------------------------------------------------
// vtp_mac
// shared multiply-accumulate with rounding and saturation to 32 bits
// ----------------------------------------------------------------------------
module vtp_mac #(
    parameter int FRAC_BITS = vtp_pkg::VTP_FRAC_BITS
) (
    input  logic                  i_clk,
    input  vtp_pkg::t_vtp_mac_ctl i_ctl,
    input  logic signed [31:0]    i_a,
    input  logic signed [31:0]    i_b,
    output logic signed [31:0]    o_res
);
    import vtp_pkg::*;

    localparam int ACC_W = 66;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] rnd;
    logic [ACC_W-32:0]       upper;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc) begin
            r_acc <= i_ctl.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // round half up, then clamp
    always_comb begin
        rnd   = (r_acc + HALF) >>> FRAC_BITS;
        upper = rnd[ACC_W-1:31];
        if ((&upper) || !(|upper)) begin
            o_res = rnd[31:0];
        end else begin
            o_res = rnd[ACC_W-1] ? VTP_MIN32 : VTP_MAX32;
        end
    end

endmodule

// ===== sv/vtp_div.sv =====
// ----------------------------------------------------------------------------
// vtp_div
// restoring divider for the perspective divide, one quotient bit a cycle
// ----------------------------------------------------------------------------
module vtp_div #(
    parameter int FRAC_BITS = vtp_pkg::VTP_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic [31:0]        i_mag,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import vtp_pkg::*;

    localparam int NW  = 33 + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM = NW'(33'h0_8000_0000);

    logic [NW-1:0] r_n;
    logic [31:0]   r_rem;
    logic [31:0]   r_mag;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [31:0]   abs_num;
    logic [NW-1:0] dividend;
    logic [32:0]   rem_sh;
    logic          ge;
    logic [31:0]   q_low;

    assign abs_num  = i_num[31] ? 32'(-i_num) : i_num;
    assign dividend = (NW'(abs_num) << FRAC_BITS) + NW'(i_mag >> 1);
    assign rem_sh   = {r_rem, r_n[NW-1]};
    assign ge       = rem_sh >= {1'b0, r_mag};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= dividend;
            r_rem <= '0;
            r_mag <= i_mag;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_mag}) : rem_sh[31:0];
            r_n   <= {r_n[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign back on, clamp to 32 bits
    always_comb begin
        q_low = r_n[31:0];
        if (r_neg) begin
            o_quot = (r_n > LIM) ? VTP_MIN32 : 32'(-q_low);
        end else begin
            o_quot = (r_n >= LIM) ? VTP_MAX32 : q_low;
        end
    end

    assign o_done = r_done;

endmodule

// ===== sv/vertex_transform_pipeline.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_pipeline
// world, view, projection and viewport transform of vertices on one shared
// multiply-accumulate unit and one serial divider
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | to block  | i_in_valid / o_in_stall | i_in_data  (t_vtp_in)
//  out     | from block| o_out_valid / i_out_stall| o_out_data (t_vtp_out)
//
//  a load item is written to the coefficient store and the block stays idle;
//  a vertex item runs through the four matrices on the single multiplier,
//  each product read, multiplied and accumulated in turn, and unless w is
//  zero, x, y and z pass the one-bit per cycle divider (Q16.16 by default)
//  reset is synchronous and active low; the coefficient store reads zero
//  until an entry is written, through per-entry valid bits
//  o_in_stall is high while a vertex is in work; a stalled output holds its
//  item and the sequencer waits before handing over the next result
// ----------------------------------------------------------------------------
module vertex_transform_pipeline #(
    parameter int FRAC_BITS = vtp_pkg::VTP_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vtp_pkg::t_vtp_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vtp_pkg::t_vtp_out o_out_data
);
    import vtp_pkg::*;

    // 1.0 in the working format
    localparam logic signed [31:0] UNIT = 32'sd1 <<< FRAC_BITS;

    t_vtp_state n_state, r_state;

    // operand vector and result vector of the current matrix
    logic signed [31:0] r_vec [4];
    logic signed [31:0] r_res [4];
    logic [1:0]         r_mat;
    logic [3:0]         r_k;        // column in [3:2], row in [1:0]
    logic [1:0]         r_c;        // component under division
    logic               r_wz;

    logic               r_out_valid;
    t_vtp_out           r_out;

    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               mat_last;
    logic               w_is_zero;
    logic [31:0]        w_mag;

    t_vtp_mac_ctl       mac_ctl;
    logic signed [31:0] mac_res;
    logic signed [31:0] rdata;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign mat_last  = (r_k == 4'd15);
    assign w_is_zero = (r_res[3] == 32'sd0);
    assign w_mag     = r_res[3][31] ? 32'(-r_res[3]) : r_res[3];

    // coefficient store, address is matrix, row, column
    vtp_coef_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (in_acc && (i_in_data.kind == KIND_LOAD)),
        .i_waddr ({i_in_data.matrix_select, i_in_data.element_index}),
        .i_wdata (i_in_data.coefficient),
        .i_raddr ({r_mat, r_k[1:0], r_k[3:2]}),
        .o_rdata (rdata)
    );

    vtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (r_vec[r_k[1:0]]),
        .i_b   (rdata),
        .o_res (mac_res)
    );

    vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_res[r_c]),
        .i_mag   (w_mag),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.kind == KIND_VERTEX)) n_state = S_RD;
            end
            S_RD:  n_state = S_MUL;
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = (r_k[1:0] == 2'd3) ? S_COL : S_RD;
            S_COL: begin
                if (!mat_last)               n_state = S_RD;
                else if (r_mat == MAT_PROJ)  n_state = S_DIVSEL;
                else                         n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = (r_mat == MAT_PORT) ? S_IDLE : S_RD;
            end
            S_DIVSEL: n_state = w_is_zero ? S_RD : S_DIVGO;
            S_DIVGO:  n_state = S_DIVWAIT;
            S_DIVWAIT: begin
                if (div_done) n_state = (r_c == 2'd2) ? S_RD : S_DIVGO;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        mac_ctl    = '0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_MUL: mac_ctl.mul = 1'b1;
            S_ACC: begin
                mac_ctl.acc   = 1'b1;
                mac_ctl.first = (r_k[1:0] == 2'd0);
            end
            S_EMIT:  out_load  = out_free;
            S_DIVGO: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.kind == KIND_VERTEX)) begin
                    r_vec[0] <= i_in_data.pos_x;
                    r_vec[1] <= i_in_data.pos_y;
                    r_vec[2] <= i_in_data.pos_z;
                    r_vec[3] <= UNIT;
                    r_mat    <= MAT_WORLD;
                    r_k      <= 4'd0;
                end
            end
            S_ACC: begin
                if (r_k[1:0] != 2'd3) r_k <= r_k + 4'd1;
            end
            S_COL: begin
                r_res[r_k[3:2]] <= mac_res;
                if (!mat_last) r_k <= r_k + 4'd1;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out.stage  <= (r_mat == MAT_PORT) ? STAGE_SCREEN : r_mat;
                    r_out.out_x  <= r_res[0];
                    r_out.out_y  <= r_res[1];
                    r_out.out_z  <= r_res[2];
                    r_out.out_w  <= r_res[3];
                    r_out.w_zero <= (r_mat == MAT_PORT) && r_wz;
                    r_out.last   <= (r_mat == MAT_PORT);
                    r_vec        <= r_res;
                    r_mat        <= r_mat + 2'd1;
                    r_k          <= 4'd0;
                end
            end
            S_DIVSEL: begin
                r_wz <= w_is_zero;
                r_c  <= 2'd0;
                r_k  <= 4'd0;
                // zero w: components go to the rail that matches their sign
                if (w_is_zero) begin
                    r_vec[0] <= r_res[0][31] ? VTP_MIN32 : VTP_MAX32;
                    r_vec[1] <= r_res[1][31] ? VTP_MIN32 : VTP_MAX32;
                    r_vec[2] <= r_res[2][31] ? VTP_MIN32 : VTP_MAX32;
                    r_vec[3] <= UNIT;
                    r_mat    <= MAT_PORT;
                end
            end
            S_DIVWAIT: begin
                if (div_done) begin
                    r_vec[r_c] <= div_quot;
                    r_c        <= r_c + 2'd1;
                    if (r_c == 2'd2) begin
                        r_vec[3] <= UNIT;
                        r_mat    <= MAT_PORT;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
